FILE: src/rmpr_pkg.sv
// ----------------------------------------------------------------------------
// rmpr_pkg
// Shared constants for the relocation map pointer resolver.
// ----------------------------------------------------------------------------
package rmpr_pkg;

    // Largest data section the mark bitmap covers, in bytes.
    localparam int unsigned MAX_DATA_BYTES_DEF = 1048576;

    // Fixed widths of the request and result fields.
    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SIZE_W   = 21;
    localparam int unsigned STATUS_W = 2;

    // Width of a pointer field in bytes.
    localparam int unsigned FIELD_BYTES = 4;

    // Mark bits held in one bitmap row.
    localparam int unsigned ROW_BITS = 8;
    localparam int unsigned BIT_W    = 3;

    // Configuration port.
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;
    localparam logic [APB_AW-3:0] REG_SECTION_LEN = '0;

    // Request operations.
    localparam logic OP_MARK    = 1'b0;
    localparam logic OP_RESOLVE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERR  = 2'd2;

endpackage

FILE: src/relocation_map_pointer_resolver.sv
// ----------------------------------------------------------------------------
// relocation_map_pointer_resolver
// Per-byte relocation mark bitmap with sticky bad-archive tracking.
// ----------------------------------------------------------------------------
// Each request first reads its bitmap row from the mark memory; the block
// then checks it, writes the row back for a good mark and loads the result
// register, waiting there while the result side stalls. A new request is
// taken only after that, so one request is in flight at a time. After reset
// the block first clears the bitmap, one row of eight marks per cycle;
// in_stall stays high during that pass, while configuration writes are taken
// at any time.
module relocation_map_pointer_resolver #(
    parameter int unsigned MAX_DATA_BYTES = rmpr_pkg::MAX_DATA_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rmpr_pkg::APB_AW-1:0]    paddr,
    input  logic [rmpr_pkg::APB_DW-1:0]    pwdata,
    output logic [rmpr_pkg::APB_DW-1:0]    prdata,
    output logic                           pready,

    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [rmpr_pkg::OFFSET_W-1:0]  field_offset,
    input  logic [rmpr_pkg::WORD_W-1:0]    word_value,

    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [rmpr_pkg::STATUS_W-1:0]  status,
    output logic [rmpr_pkg::SIZE_W-1:0]    target_offset
);
    import rmpr_pkg::*;

    localparam int unsigned MARK_W = $clog2(MAX_DATA_BYTES);
    localparam int unsigned ROW_AW = (MARK_W > BIT_W) ? MARK_W - BIT_W : 1;
    localparam int unsigned ROWS   = (MAX_DATA_BYTES + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned CMP_W  = OFFSET_W + 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t                state_reg;
    logic [ROW_AW-1:0]     clr_row_reg;

    logic [SIZE_W-1:0]     section_len_reg;
    logic                  archive_bad_reg;

    // Request fields and checks captured at acceptance.
    logic                  op_reg;
    logic                  fits_reg;
    logic                  word_ok_reg;
    logic                  word_zero_reg;
    logic [BIT_W-1:0]      bit_reg;
    logic [ROW_AW-1:0]     row_reg;
    logic [SIZE_W-1:0]     word_low_reg;

    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [SIZE_W-1:0]     target_reg;

    // Mark bitmap.
    logic [ROW_BITS-1:0]   mark_mem [ROWS];
    logic [ROW_BITS-1:0]   rd_data_reg;

    logic                  mem_we;
    logic [ROW_AW-1:0]     mem_waddr;
    logic [ROW_BITS-1:0]   mem_wdata;
    logic                  mem_re;
    logic [ROW_AW-1:0]     mem_raddr;

    logic                  cfg_write;
    logic                  in_accept;
    logic                  out_free;
    logic                  result_load;
    logic [CMP_W-1:0]      eff_size;
    logic                  fits;
    logic                  word_ok;
    logic [ROW_AW-1:0]     req_row;
    logic                  marked;
    logic                  set_mark;
    logic                  set_bad;
    logic [STATUS_W-1:0]   status_next;
    logic [SIZE_W-1:0]     target_next;
    logic [ROW_BITS-1:0]   bit_mask;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_AW-1:2] == REG_SECTION_LEN);

    always_comb
    begin
        if (paddr[APB_AW-1:2] == REG_SECTION_LEN)
        begin
            prdata = APB_DW'(section_len_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            section_len_reg <= '0;
        end
        else if (cfg_write)
        begin
            section_len_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Request checks
    // ------------------------------------------------------------------
    always_comb
    begin
        if (CMP_W'(section_len_reg) > CMP_W'(MAX_DATA_BYTES))
        begin
            eff_size = CMP_W'(MAX_DATA_BYTES);
        end
        else
        begin
            eff_size = CMP_W'(section_len_reg);
        end
    end

    // A field fits when all four of its bytes lie inside the data section.
    assign fits    = (CMP_W'(field_offset) + CMP_W'(FIELD_BYTES)) <= eff_size;
    assign word_ok = CMP_W'(word_value) <= eff_size;
    assign req_row = ROW_AW'(field_offset >> BIT_W);

    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign result_load = (state_reg == ST_LOOKUP) && out_free;

    // ------------------------------------------------------------------
    // Result and write-back
    // ------------------------------------------------------------------
    assign bit_mask = ROW_BITS'(1) << bit_reg;
    assign marked   = |(rd_data_reg & bit_mask);

    always_comb
    begin
        status_next = STATUS_ERR;
        target_next = '0;
        set_mark    = 1'b0;
        set_bad     = 1'b0;
        if (!archive_bad_reg)
        begin
            case (op_reg)
                OP_MARK:
                begin
                    if (fits_reg && word_ok_reg)
                    begin
                        status_next = STATUS_OK;
                        set_mark    = 1'b1;
                    end
                    else
                    begin
                        set_bad = 1'b1;
                    end
                end
                OP_RESOLVE:
                begin
                    if (fits_reg)
                    begin
                        if (!marked)
                        begin
                            status_next = word_zero_reg ? STATUS_ZERO : STATUS_ERR;
                        end
                        else if (word_ok_reg)
                        begin
                            status_next = STATUS_OK;
                            target_next = word_low_reg;
                        end
                    end
                end
                default:
                begin
                    status_next = STATUS_ERR;
                end
            endcase
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = row_reg;
        mem_wdata = rd_data_reg | bit_mask;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_row_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_LOOKUP && out_free && set_mark)
        begin
            mem_we = 1'b1;
        end
    end

    // Only rows of fields inside the data section are ever read.
    assign mem_re    = in_accept && fits && !archive_bad_reg;
    assign mem_raddr = req_row;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mark_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mark_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg        <= op;
            fits_reg      <= fits;
            word_ok_reg   <= word_ok;
            word_zero_reg <= (word_value == '0);
            bit_reg       <= field_offset[BIT_W-1:0];
            row_reg       <= req_row;
            word_low_reg  <= word_value[SIZE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_row_reg     <= '0;
            archive_bad_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_reg      <= STATUS_ZERO;
            target_reg      <= '0;
        end
        else
        begin
            if (result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_row_reg == ROW_AW'(ROWS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_row_reg <= clr_row_reg + ROW_AW'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (out_free)
                    begin
                        status_reg <= status_next;
                        target_reg <= target_next;
                        if (set_bad)
                        begin
                            archive_bad_reg <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign target_offset = target_reg;

endmodule

FILE: src/rmpr_checker.sv
// ----------------------------------------------------------------------------
// rmpr_port_checks
// Port-level checks for the relocation map pointer resolver.
// ----------------------------------------------------------------------------
module rmpr_port_checks (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [rmpr_pkg::STATUS_W-1:0]  status,
    input  logic [rmpr_pkg::SIZE_W-1:0]    target_offset
);
    import rmpr_pkg::*;

    // The block works on one request at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted in back-to-back cycles");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_ZERO || status == STATUS_OK
                       || status == STATUS_ERR))
        else $error("undefined status code");

    // Only a resolved pointer carries a target.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target_offset != '0 |-> status == STATUS_OK)
        else $error("target offset given without a resolved pointer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
                                   && $stable(target_offset))
        else $error("stalled result changed");

endmodule

bind relocation_map_pointer_resolver rmpr_port_checks u_rmpr_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .target_offset (target_offset)
);
